// ===== rtl/smp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding max pool package
// Register codes, register widths and reset values, and fixed sizes shared
// by the pooling block and its channel interfaces.
// ----------------------------------------------------------------------------
package smp_pkg;

    localparam int CFG_W      = 13;
    localparam int REG_IDX_W  = 1;
    localparam int ROW_W      = 12;
    localparam int ROW_LIMIT  = 4096;
    localparam int FIFO_DEPTH = 4;

    localparam logic [CFG_W-1:0] ROW_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_ROWS_RST = 13'd480;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROW_WIDTH  = 1'b0,
        REG_FRAME_ROWS = 1'b1
    } cfg_reg_t;

endpackage
`default_nettype wire

// ===== rtl/smp_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding max pool channel interfaces
// Sample input channel, pooled result channel and register write channel.
// ----------------------------------------------------------------------------
interface smp_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_start;

    modport source (output valid, output sample, output frame_start, input ready);
    modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface smp_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] pooled_max;
    logic                          frame_last;

    modport source (output valid, output pooled_max, output frame_last, input ready);
    modport sink   (input valid, input pooled_max, input frame_last, output ready);
endinterface

interface smp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [smp_pkg::REG_IDX_W-1:0]  index;
    logic [smp_pkg::CFG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/smp_line_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding max pool line buffer
// Holds the previous POOL-1 rows, one word of POOL-1 samples per column,
// with a registered read and a bypass for a read of the word being written.
// ----------------------------------------------------------------------------
module smp_line_buf #(
    parameter int POOL        = 2,
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int ADDR_W      = 12
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 rd_en,
    input  wire logic [ADDR_W-1:0]                    rd_addr,
    input  wire logic                                 wr_en,
    input  wire logic [ADDR_W-1:0]                    wr_addr,
    input  wire logic [POOL-2:0][SAMPLE_BITS-1:0]     wr_data,
    output logic      [POOL-2:0][SAMPLE_BITS-1:0]     rd_data
);

    logic [POOL-2:0][SAMPLE_BITS-1:0] mem [MAX_WIDTH];
    logic [POOL-2:0][SAMPLE_BITS-1:0] rd_q_reg;
    logic [POOL-2:0][SAMPLE_BITS-1:0] byp_data_reg;
    logic                             byp_hit_reg;
    logic                             byp_hit_next;

    assign byp_hit_next = rd_en && wr_en && (rd_addr == wr_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            byp_hit_reg <= byp_hit_next;
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : rd_q_reg;

endmodule
`default_nettype wire

// ===== rtl/smp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding max pool window cell
// Holds the maximum of one window column, passes it to the next cell on each
// item and merges it into the running window maximum along the chain.
// ----------------------------------------------------------------------------
module smp_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          shift,
    input  wire logic signed [SAMPLE_BITS-1:0] col_in,
    input  wire logic signed [SAMPLE_BITS-1:0] acc_in,
    output logic signed      [SAMPLE_BITS-1:0] col_out,
    output logic signed      [SAMPLE_BITS-1:0] acc_out
);

    logic signed [SAMPLE_BITS-1:0] col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;
    assign acc_out = (col_reg > acc_in) ? col_reg : acc_in;

endmodule
`default_nettype wire

// ===== rtl/smp_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding max pool result queue
// Small queue of finished results in front of the output channel, so that
// the pipeline keeps flowing while the consumer stalls.
// ----------------------------------------------------------------------------
module smp_out_fifo #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        push,
    input  wire logic signed [SAMPLE_BITS-1:0]               push_max,
    input  wire logic                                        push_last,
    output logic [$clog2(smp_pkg::FIFO_DEPTH+1)-1:0]         count,
    smp_out_if.source                                        pool_out
);
    import smp_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic signed [SAMPLE_BITS-1:0] max_q [FIFO_DEPTH];
    logic                          last_q [FIFO_DEPTH];
    logic [PTR_W-1:0]              wr_ptr_reg;
    logic [PTR_W-1:0]              rd_ptr_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          pop;

    assign pop = pool_out.valid && pool_out.ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            max_q[wr_ptr_reg]  <= push_max;
            last_q[wr_ptr_reg] <= push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign count               = count_reg;
    assign pool_out.valid      = (count_reg != '0);
    assign pool_out.pooled_max = max_q[rd_ptr_reg];
    assign pool_out.frame_last = last_q[rd_ptr_reg];

    ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNT_W'(FIFO_DEPTH)) || pop)
        else $error("result queue overflow");

    ap_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("result queue underflow");

    ap_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("result queue count did not follow a push");

endmodule
`default_nettype wire

// ===== rtl/sliding_max_pool_2d.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding 2-D max pool
// Stride-1 POOL by POOL maximum pooling over a raster-order sample stream.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while its input is ready and gives
// one result per clock while the consumer takes them, once the POOL by POOL
// window lies inside the frame; the last result of a frame carries
// frame_last. A result passes through the registered line-buffer read and
// the column maximum, which loads the chain of window cells, and then the
// running maximum along the chain, which is written into a four-entry result
// queue. Input ready drops when the queue entries in use plus the items in
// the two pipeline stages reach the queue depth. The line buffer holds POOL-1
// rows of MAX_WIDTH samples and needs no clearing after reset. Register
// writes are taken at any time and act on the next sample.
module sliding_max_pool_2d #(
    parameter int POOL        = 2,
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    smp_in_if.sink      pix_in,
    smp_out_if.source   pool_out,
    smp_cfg_if.sink     cfg
);
    import smp_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int HCMP_W = ROW_W + 1;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
        {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [CFG_W-1:0]  row_width_reg;
    logic [CFG_W-1:0]  frame_rows_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;

    logic              in_acc;
    logic [COL_W-1:0]  c_cur;
    logic [ROW_W-1:0]  r_cur;
    logic [WCMP_W-1:0] w_raw;
    logic [WCMP_W-1:0] w_eff;
    logic [HCMP_W-1:0] h_raw;
    logic [HCMP_W-1:0] h_eff;
    logic              col_wrap;
    logic              row_wrap;
    logic              produce;
    logic              last_pos;

    logic                          b_valid_reg;
    logic signed [SAMPLE_BITS-1:0] b_sample_reg;
    logic [COL_W-1:0]              b_addr_reg;
    logic                          b_prod_reg;
    logic                          b_last_reg;
    logic                          c_valid_reg;
    logic                          c_prod_reg;
    logic                          c_last_reg;

    logic [POOL-2:0][SAMPLE_BITS-1:0] old_word;
    logic [POOL-2:0][SAMPLE_BITS-1:0] new_word;
    logic signed [SAMPLE_BITS-1:0]    col_max;

    logic signed [SAMPLE_BITS-1:0] held [POOL];
    logic signed [SAMPLE_BITS-1:0] acc [POOL+1];

    logic [CNT_W-1:0] fifo_count;
    logic [CNT_W:0]   occupancy;

    // Register port.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg  <= ROW_WIDTH_RST;
            frame_rows_reg <= FRAME_ROWS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_ROW_WIDTH:  row_width_reg  <= cfg.data;
                REG_FRAME_ROWS: frame_rows_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    // Input handshake, counted against the result queue.
    assign occupancy = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(b_valid_reg)
                     + (CNT_W+1)'(c_valid_reg);
    assign pix_in.ready = (occupancy < (CNT_W+1)'(FIFO_DEPTH));
    assign in_acc = pix_in.valid && pix_in.ready;

    // Frame geometry and position of the incoming sample.
    always_comb
    begin
        w_raw = WCMP_W'(row_width_reg);
        if (w_raw == '0)
        begin
            w_eff = WCMP_W'(1);
        end
        else if (w_raw > WCMP_W'(MAX_WIDTH))
        begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_raw;
        end

        h_raw = HCMP_W'(frame_rows_reg);
        if (h_raw == '0)
        begin
            h_eff = HCMP_W'(1);
        end
        else if (h_raw > HCMP_W'(ROW_LIMIT))
        begin
            h_eff = HCMP_W'(ROW_LIMIT);
        end
        else
        begin
            h_eff = h_raw;
        end

        c_cur = pix_in.frame_start ? '0 : col_reg;
        r_cur = pix_in.frame_start ? '0 : row_reg;

        col_wrap = (WCMP_W'(c_cur) + WCMP_W'(1)) >= w_eff;
        row_wrap = (HCMP_W'(r_cur) + HCMP_W'(1)) >= h_eff;
        produce  = (r_cur >= ROW_W'(POOL - 1)) && (c_cur >= COL_W'(POOL - 1));
        last_pos = ((HCMP_W'(r_cur) + HCMP_W'(1)) == h_eff)
                && ((WCMP_W'(c_cur) + WCMP_W'(1)) == w_eff);

        col_next = col_wrap ? '0 : c_cur + COL_W'(1);
        if (!col_wrap)
        begin
            row_next = r_cur;
        end
        else if (row_wrap)
        begin
            row_next = '0;
        end
        else
        begin
            row_next = r_cur + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            b_prod_reg  <= 1'b0;
            b_last_reg  <= 1'b0;
            c_valid_reg <= 1'b0;
            c_prod_reg  <= 1'b0;
            c_last_reg  <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            b_valid_reg <= in_acc;
            b_prod_reg  <= in_acc && produce;
            b_last_reg  <= last_pos;
            c_valid_reg <= b_valid_reg;
            c_prod_reg  <= b_prod_reg;
            c_last_reg  <= b_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            b_sample_reg <= pix_in.sample;
            b_addr_reg   <= c_cur;
        end
    end

    // Line buffer: read at acceptance, age the column in the cycle after it.
    smp_line_buf #(
        .POOL        (POOL),
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_W      (COL_W)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (c_cur),
        .wr_en   (b_valid_reg),
        .wr_addr (b_addr_reg),
        .wr_data (new_word),
        .rd_data (old_word)
    );

    always_comb
    begin
        new_word[0] = b_sample_reg;
        for (int k = 1; k < POOL - 1; k++)
        begin
            new_word[k] = old_word[k-1];
        end

        col_max = b_sample_reg;
        for (int k = 0; k < POOL - 1; k++)
        begin
            if ($signed(old_word[k]) > col_max)
            begin
                col_max = $signed(old_word[k]);
            end
        end
    end

    // Chain of window cells, one per window column.
    assign acc[0] = SAMPLE_MIN;

    for (genvar j = 0; j < POOL; j++)
    begin : g_cell
        smp_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (b_valid_reg),
            .col_in  ((j == 0) ? col_max : held[(j == 0) ? 0 : j - 1]),
            .acc_in  (acc[j]),
            .col_out (held[j]),
            .acc_out (acc[j+1])
        );
    end

    smp_out_fifo #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (c_valid_reg && c_prod_reg),
        .push_max  (acc[POOL]),
        .push_last (c_last_reg),
        .count     (fifo_count),
        .pool_out  (pool_out)
    );

    ap_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= (CNT_W+1)'(FIFO_DEPTH))
        else $error("items in flight exceed the result queue");

    ap_frame_start_col: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && pix_in.frame_start) |=> (b_addr_reg == '0) && b_valid_reg)
        else $error("frame start did not restart the column");

    ap_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |=> c_valid_reg && (c_prod_reg == $past(b_prod_reg)))
        else $error("pipeline stage lost an item");

endmodule
`default_nettype wire
